/* sv/lprt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route table package
// Shared types, codes and helper functions for the longest-prefix route table.
// ----------------------------------------------------------------------------
package lprt_pkg;

    // Field widths fixed by the item format.
    localparam int ADDR_W      = 32;
    localparam int IFACE_W     = 4;
    localparam int PLEN_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int IDX_OUT_W   = 4;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Request kinds.
    typedef enum logic {
        REQ_ADD    = 1'b0,
        REQ_LOOKUP = 1'b1
    } t_req_kind;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_HIT   = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FIN
    } t_back_state;

    // A classified request as it travels from the front to the back.
    typedef struct packed {
        t_req_kind           kind;
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   gw;
        logic [IFACE_W-1:0]  iface;
        logic [ADDR_W-1:0]   cost;
        logic                has_gw;
        logic [PLEN_W-1:0]   plen;
    } t_req;

    // One stored route.
    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   gw;
        logic [IFACE_W-1:0]  iface;
        logic [ADDR_W-1:0]   cost;
        logic                has_gw;
        logic [PLEN_W-1:0]   plen;
    } t_route;

    // Number of one bits in a mask; this is the prefix length.
    function automatic logic [PLEN_W-1:0] ones_in(input logic [ADDR_W-1:0] v);
        logic [PLEN_W-1:0] n;
        n = '0;
        for (int k = 0; k < ADDR_W; k++) begin
            n = n + PLEN_W'(v[k]);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* sv/lprt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route table front end
// Accepts request items, classifies them and precomputes the prefix length
// and the gateway mark, then hands them to the queue.
// ----------------------------------------------------------------------------
module lprt_front
    import lprt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_req_type,
    input  wire logic [ADDR_W-1:0]   i_dest_addr,
    input  wire logic [ADDR_W-1:0]   i_net_mask,
    input  wire logic [ADDR_W-1:0]   i_gateway_addr,
    input  wire logic [IFACE_W-1:0]  i_iface_id,
    input  wire logic [ADDR_W-1:0]   i_route_metric,
    output logic                     o_push,
    output t_req                     o_push_item,
    input  wire logic                i_push_ready
);

    logic  r_vld;
    t_req  r_item;
    t_req  w_item;
    logic  w_accept;

    // The stage holds an item only while the queue refuses it.
    assign o_stall  = r_vld && !i_push_ready;
    assign w_accept = i_valid && !o_stall;

    // Classify the incoming item.
    always_comb begin
        w_item.kind   = t_req_kind'(i_req_type);
        w_item.dest   = i_dest_addr;
        w_item.mask   = i_net_mask;
        w_item.gw     = i_gateway_addr;
        w_item.iface  = i_iface_id;
        w_item.cost   = i_route_metric;
        w_item.has_gw = (i_gateway_addr != '0);
        w_item.plen   = ones_in(i_net_mask);
    end

    // Valid flag of the front register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (i_push_ready) begin
            r_vld <= 1'b0;
        end
    end

    // Payload of the front register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_item;
        end
    end

    assign o_push      = r_vld;
    assign o_push_item = r_item;

endmodule
`default_nettype wire

/* sv/lprt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route table request queue
// A short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module lprt_queue
    import lprt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_req  i_push_item,
    output logic       o_push_ready,
    output logic       o_pop_valid,
    output t_req       o_pop_item,
    input  wire logic  i_pop
);

    t_req               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && o_push_ready;
    assign w_do_pop     = i_pop && o_pop_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

/* sv/lprt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Route table back end
// Holds the route memory, appends routes and scans it one entry per cycle
// for the longest matching prefix, then loads the output register.
// ----------------------------------------------------------------------------
module lprt_back
    import lprt_pkg::*;
#(
    parameter int MAX_ROUTES = 16
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire t_req                  i_q_item,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [IDX_OUT_W-1:0]       o_entry_index,
    output logic [ADDR_W-1:0]          o_out_gateway,
    output logic [IFACE_W-1:0]         o_out_iface,
    output logic [ADDR_W-1:0]          o_out_metric,
    output logic                       o_uses_gateway,
    output logic [PLEN_W-1:0]          o_prefix_len
);

    localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CNT_W = $clog2(MAX_ROUTES + 1);

    t_back_state            r_state;
    t_back_state            n_state;

    t_route                 r_mem [MAX_ROUTES];
    t_route                 r_rd_data;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [CNT_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;

    t_req                   r_req;
    logic                   r_found;
    t_route                 r_best;
    logic [IDX_W-1:0]       r_best_idx;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [IDX_OUT_W-1:0]   r_out_index;
    logic [ADDR_W-1:0]      r_out_gw;
    logic [IFACE_W-1:0]     r_out_iface;
    logic [ADDR_W-1:0]      r_out_cost;
    logic                   r_out_has_gw;
    logic [PLEN_W-1:0]      r_out_plen;

    logic                   w_full;
    logic                   w_out_free;
    logic                   w_rd_issue;
    logic                   w_hit;
    logic                   w_take;
    logic                   w_load_out;
    logic                   w_wr_en;
    t_route                 w_wr_route;
    logic [IDX_W+IDX_OUT_W-1:0] w_add_idx_ext;
    logic [IDX_W+IDX_OUT_W-1:0] w_best_idx_ext;

    t_status                w_res_status;
    logic [IDX_OUT_W-1:0]   w_res_index;
    logic [ADDR_W-1:0]      w_res_gw;
    logic [IFACE_W-1:0]     w_res_iface;
    logic [ADDR_W-1:0]      w_res_cost;
    logic                   w_res_has_gw;
    logic [PLEN_W-1:0]      w_res_plen;

    assign w_full     = (r_count == CNT_W'(MAX_ROUTES));
    assign w_out_free = !r_out_valid || !i_stall;

    // Match test on the entry read in the previous cycle.
    assign w_hit  = r_rd_vld &&
                    (((r_req.dest ^ r_rd_data.dest) & r_rd_data.mask) == '0);
    assign w_take = w_hit && (!r_found || (r_rd_data.plen >= r_best.plen));

    // Slot numbers reported as their low four bits.
    assign w_add_idx_ext  = {{IDX_OUT_W{1'b0}}, r_count[IDX_W-1:0]};
    assign w_best_idx_ext = {{IDX_OUT_W{1'b0}}, r_best_idx};

    // Route written by an add.
    always_comb begin
        w_wr_route.dest   = r_req.dest;
        w_wr_route.mask   = r_req.mask;
        w_wr_route.gw     = r_req.gw;
        w_wr_route.iface  = r_req.iface;
        w_wr_route.cost   = r_req.cost;
        w_wr_route.has_gw = r_req.has_gw;
        w_wr_route.plen   = r_req.plen;
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes.
    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        w_rd_issue = 1'b0;
        w_load_out = 1'b0;
        w_wr_en    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.kind == REQ_LOOKUP) begin
                        n_state = BK_SCAN;
                    end else begin
                        n_state = BK_FIN;
                    end
                end
            end
            BK_SCAN: begin
                w_rd_issue = (r_rd_ptr < r_count);
                if (!w_rd_issue && !r_rd_vld) begin
                    n_state = BK_FIN;
                end
            end
            BK_FIN: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_wr_en    = (r_req.kind == REQ_ADD) && !w_full;
                    n_state    = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Result fields for the finished item.
    always_comb begin
        w_res_status = ST_MISS;
        w_res_index  = '0;
        w_res_gw     = '0;
        w_res_iface  = '0;
        w_res_cost   = '0;
        w_res_has_gw = 1'b0;
        w_res_plen   = '0;
        if (r_req.kind == REQ_ADD) begin
            if (w_full) begin
                w_res_status = ST_FULL;
            end else begin
                w_res_status = ST_ADDED;
                w_res_index  = w_add_idx_ext[IDX_OUT_W-1:0];
            end
        end else if (r_found) begin
            w_res_status = ST_HIT;
            w_res_index  = w_best_idx_ext[IDX_OUT_W-1:0];
            w_res_gw     = r_best.gw;
            w_res_iface  = r_best.iface;
            w_res_cost   = r_best.cost;
            w_res_has_gw = r_best.has_gw;
            w_res_plen   = r_best.plen;
        end
    end

    // Route memory: one write port for adds, one registered read port for scans.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= w_wr_route;
        end
        if (w_rd_issue) begin
            r_rd_data <= r_mem[r_rd_ptr[IDX_W-1:0]];
            r_rd_idx  <= r_rd_ptr[IDX_W-1:0];
        end
    end

    // Scan control, route count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_ptr    <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_issue;
            if (o_q_pop) begin
                r_rd_ptr <= '0;
                r_found  <= 1'b0;
            end else begin
                if (w_rd_issue) begin
                    r_rd_ptr <= r_rd_ptr + CNT_W'(1);
                end
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
            if (w_wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, best match and output payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req <= i_q_item;
        end
        if (w_take) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_rd_idx;
        end
        if (w_load_out) begin
            r_out_status <= w_res_status;
            r_out_index  <= w_res_index;
            r_out_gw     <= w_res_gw;
            r_out_iface  <= w_res_iface;
            r_out_cost   <= w_res_cost;
            r_out_has_gw <= w_res_has_gw;
            r_out_plen   <= w_res_plen;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_entry_index  = r_out_index;
    assign o_out_gateway  = r_out_gw;
    assign o_out_iface    = r_out_iface;
    assign o_out_metric   = r_out_cost;
    assign o_uses_gateway = r_out_has_gw;
    assign o_prefix_len   = r_out_plen;

endmodule
`default_nettype wire

/* sv/longest_prefix_route_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Longest-prefix route table
// Stores up to MAX_ROUTES IPv4 routes and answers lookups with the longest
// matching prefix, the newest route winning a tie.
//
// Usage: a request item enters on i_valid / o_stall with its fields on the
// i_ ports; i_req_type selects add or lookup. Exactly one result item per
// request leaves on o_valid / i_stall, in request order.
// An accepted item passes the front register and the queue into the back; an
// add result is then loaded into the output register, while a lookup first
// scans the route memory one entry per cycle and drains the last read.
// The back takes one item at a time and pops no new item until the result of
// the last one is loaded into the output register.
// Reset clears the route count and all valid flags; route storage is not
// cleared, as only written slots are ever read.
// When the receiver stalls, the result holds in the output register; the back,
// queue and front still take up to four more items before o_stall rises.
// ----------------------------------------------------------------------------
module longest_prefix_route_table
    import lprt_pkg::*;
#(
    parameter int MAX_ROUTES = 16
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_req_type,
    input  wire logic [ADDR_W-1:0]     i_dest_addr,
    input  wire logic [ADDR_W-1:0]     i_net_mask,
    input  wire logic [ADDR_W-1:0]     i_gateway_addr,
    input  wire logic [IFACE_W-1:0]    i_iface_id,
    input  wire logic [ADDR_W-1:0]     i_route_metric,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [IDX_OUT_W-1:0]       o_entry_index,
    output logic [ADDR_W-1:0]          o_out_gateway,
    output logic [IFACE_W-1:0]         o_out_iface,
    output logic [ADDR_W-1:0]          o_out_metric,
    output logic                       o_uses_gateway,
    output logic [PLEN_W-1:0]          o_prefix_len
);

    logic  w_push;
    t_req  w_push_item;
    logic  w_push_ready;
    logic  w_pop_valid;
    t_req  w_pop_item;
    logic  w_pop;

    // Front: accept and classify.
    lprt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_dest_addr    (i_dest_addr),
        .i_net_mask     (i_net_mask),
        .i_gateway_addr (i_gateway_addr),
        .i_iface_id     (i_iface_id),
        .i_route_metric (i_route_metric),
        .o_push         (w_push),
        .o_push_item    (w_push_item),
        .i_push_ready   (w_push_ready)
    );

    // Queue between front and back.
    lprt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_item  (w_push_item),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_item   (w_pop_item),
        .i_pop        (w_pop)
    );

    // Back: route memory, scan and result register.
    lprt_back #(
        .MAX_ROUTES (MAX_ROUTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_pop_valid),
        .i_q_item       (w_pop_item),
        .o_q_pop        (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_entry_index  (o_entry_index),
        .o_out_gateway  (o_out_gateway),
        .o_out_iface    (o_out_iface),
        .o_out_metric   (o_out_metric),
        .o_uses_gateway (o_uses_gateway),
        .o_prefix_len   (o_prefix_len)
    );

endmodule
`default_nettype wire

/* dv/longest_prefix_route_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest-prefix route table testbench
// Drives add and lookup items into the route table and keeps its own copy of
// the routes to work out each answer. Every answer item that leaves the block
// is compared field by field with the oldest pending one. Directed items cover
// the empty table, the extreme route values, ties, non-contiguous masks, the
// default route and the full table. Random traffic follows under several
// sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module longest_prefix_route_table_tb;
    import lprt_pkg::*;

    localparam int MAX_ROUTES  = 16;
    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 1_000_000;
    // A lookup over a full table plus the front register and queue.
    localparam int TAIL_CYCLES = 2 * MAX_ROUTES + 8;

    // One answer item as the block reports it.
    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]    gw;
        logic [IFACE_W-1:0]   iface;
        logic [ADDR_W-1:0]    metric;
        logic                 uses_gw;
        logic [PLEN_W-1:0]    plen;
    } t_route_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_req_type;
    logic [ADDR_W-1:0]    i_dest_addr;
    logic [ADDR_W-1:0]    i_net_mask;
    logic [ADDR_W-1:0]    i_gateway_addr;
    logic [IFACE_W-1:0]   i_iface_id;
    logic [ADDR_W-1:0]    i_route_metric;
    logic                 o_valid;
    logic                 i_stall;
    logic [STATUS_W-1:0]  o_status;
    logic [IDX_OUT_W-1:0] o_entry_index;
    logic [ADDR_W-1:0]    o_out_gateway;
    logic [IFACE_W-1:0]   o_out_iface;
    logic [ADDR_W-1:0]    o_out_metric;
    logic                 o_uses_gateway;
    logic [PLEN_W-1:0]    o_prefix_len;

    // Shadow copy of the route table.
    logic [ADDR_W-1:0]  tbl_dest [MAX_ROUTES];
    logic [ADDR_W-1:0]  tbl_mask [MAX_ROUTES];
    logic [ADDR_W-1:0]  tbl_gw   [MAX_ROUTES];
    logic [IFACE_W-1:0] tbl_if   [MAX_ROUTES];
    logic [ADDR_W-1:0]  tbl_cost [MAX_ROUTES];
    int                 route_cnt = 0;

    t_route_answer pending_answers[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int n_added = 0, n_full = 0, n_hit = 0, n_miss = 0;

    longest_prefix_route_table #(
        .MAX_ROUTES(MAX_ROUTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_dest_addr    (i_dest_addr),
        .i_net_mask     (i_net_mask),
        .i_gateway_addr (i_gateway_addr),
        .i_iface_id     (i_iface_id),
        .i_route_metric (i_route_metric),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_entry_index  (o_entry_index),
        .o_out_gateway  (o_out_gateway),
        .o_out_iface    (o_out_iface),
        .o_out_metric   (o_out_metric),
        .o_uses_gateway (o_uses_gateway),
        .o_prefix_len   (o_prefix_len)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Run limit in case the block stops answering.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d answers pending.",
                     cycle_count, pending_answers.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // Apply one request to the shadow table and return the answer it causes.
    function automatic t_route_answer predict_route_answer(
        input t_req_kind kind, input logic [ADDR_W-1:0] dest,
        input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] gw,
        input logic [IFACE_W-1:0] ifc, input logic [ADDR_W-1:0] cost);
        t_route_answer ans;
        bit found;
        int best;
        int best_len;
        int len;
        ans      = '0;
        found    = 1'b0;
        best     = 0;
        best_len = 0;
        if (kind == REQ_ADD) begin
            if (route_cnt >= MAX_ROUTES) begin
                ans.status = ST_FULL;
            end else begin
                tbl_dest[route_cnt] = dest;
                tbl_mask[route_cnt] = mask;
                tbl_gw[route_cnt]   = gw;
                tbl_if[route_cnt]   = ifc;
                tbl_cost[route_cnt] = cost;
                ans.status = ST_ADDED;
                ans.slot   = IDX_OUT_W'(route_cnt);
                route_cnt++;
            end
        end else begin
            // Longest prefix wins; scanning upward lets the newest win a tie.
            for (int k = 0; k < route_cnt; k++) begin
                if ((dest & tbl_mask[k]) == (tbl_dest[k] & tbl_mask[k])) begin
                    len = $countones(tbl_mask[k]);
                    if (!found || len >= best_len) begin
                        found    = 1'b1;
                        best     = k;
                        best_len = len;
                    end
                end
            end
            if (!found) begin
                ans.status = ST_MISS;
            end else begin
                ans.status  = ST_HIT;
                ans.slot    = IDX_OUT_W'(best);
                ans.gw      = tbl_gw[best];
                ans.iface   = tbl_if[best];
                ans.metric  = tbl_cost[best];
                ans.uses_gw = (tbl_gw[best] != '0);
                ans.plen    = PLEN_W'(best_len);
            end
        end
        return ans;
    endfunction

    function automatic void check_field(input string field,
                                        input logic [ADDR_W-1:0] exp_v,
                                        input logic [ADDR_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Compare every accepted answer item with the oldest pending one.
    always @(posedge i_clk) begin : check_answers
        t_route_answer exp_ans;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected answer: status %0h slot %0h",
                         $time, o_status, o_entry_index);
                fail_count++;
            end else begin
                exp_ans = pending_answers.pop_front();
                check_field("status",       exp_ans.status,  o_status);
                check_field("entry_index",  exp_ans.slot,    o_entry_index);
                check_field("out_gateway",  exp_ans.gw,      o_out_gateway);
                check_field("out_iface",    exp_ans.iface,   o_out_iface);
                check_field("out_metric",   exp_ans.metric,  o_out_metric);
                check_field("uses_gateway", exp_ans.uses_gw, o_uses_gateway);
                check_field("prefix_len",   exp_ans.plen,    o_prefix_len);
                case (exp_ans.status)
                    ST_ADDED: n_added++;
                    ST_FULL:  n_full++;
                    ST_HIT:   n_hit++;
                    default:  n_miss++;
                endcase
            end
        end
    end

    // Send one request item; valid stays high afterwards until the next
    // falling edge changes it.
    task automatic send_request(input t_req_kind kind, input logic [ADDR_W-1:0] dest,
                                input logic [ADDR_W-1:0] mask,
                                input logic [ADDR_W-1:0] gw,
                                input logic [IFACE_W-1:0] ifc,
                                input logic [ADDR_W-1:0] cost);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_req_type     = kind;
        i_dest_addr    = dest;
        i_net_mask     = mask;
        i_gateway_addr = gw;
        i_iface_id     = ifc;
        i_route_metric = cost;
        do @(posedge i_clk); while (o_stall);
        pending_answers.push_back(predict_route_answer(kind, dest, mask, gw, ifc, cost));
    endtask

    task automatic send_add(input logic [ADDR_W-1:0] dest, input logic [ADDR_W-1:0] mask,
                            input logic [ADDR_W-1:0] gw, input logic [IFACE_W-1:0] ifc,
                            input logic [ADDR_W-1:0] cost);
        send_request(REQ_ADD, dest, mask, gw, ifc, cost);
    endtask

    // The route fields carry noise on a lookup, since the block ignores them.
    task automatic send_lookup(input logic [ADDR_W-1:0] addr);
        send_request(REQ_LOOKUP, addr, $urandom, $urandom, IFACE_W'($urandom), $urandom);
    endtask

    // Drop valid and hold off until every pending answer has come back.
    task automatic wait_for_answers();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Random route, often nested inside or tied with a stored one.
    task automatic add_random_route();
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] gw;
        int j;
        mask = 32'hFFFF_FFFF << (32 - $urandom_range(1, 32));
        if ($urandom_range(3) == 0) mask = $urandom;
        dest = $urandom;
        if (route_cnt > 0 && $urandom_range(1) == 1) begin
            j    = $urandom_range(route_cnt - 1);
            dest = (tbl_dest[j] & tbl_mask[j]) | ($urandom & ~tbl_mask[j]);
            if ($urandom_range(2) == 0) mask = tbl_mask[j];
        end
        gw = ($urandom_range(3) == 0) ? '0 : $urandom;
        send_add(dest, mask, gw, IFACE_W'($urandom_range(15)), $urandom);
    endtask

    // Mostly addresses inside a stored prefix, some fully random.
    function automatic logic [ADDR_W-1:0] random_lookup_addr();
        int j;
        if (route_cnt > 0 && $urandom_range(9) < 7) begin
            j = $urandom_range(route_cnt - 1);
            return (tbl_dest[j] & tbl_mask[j]) | ($urandom & ~tbl_mask[j]);
        end
        return $urandom;
    endfunction

    task automatic run_random_phase(input int n_items, input int add_limit,
                                    input int add_pct, input int idle_pct,
                                    input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) begin
            if (route_cnt < add_limit && $urandom_range(99) < add_pct) begin
                add_random_route();
            end else begin
                send_lookup(random_lookup_addr());
            end
        end
    endtask

    // Lookups before any route exists must miss.
    task automatic test_empty_table();
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
    endtask

    // Routes at the extremes of every field, a tie and non-contiguous masks.
    task automatic test_add_extremes();
        send_add(32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 4'd0,  32'h0000_0000);
        send_add(32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001, 4'd15, 32'hFFFF_FFFF);
        send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
        send_add(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 4'd1,  32'h0000_0001);
        // Same prefix as the second route, so this newer one must win.
        send_add(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0101, 4'd7,  32'd100);
        send_add(32'h5A5A_5A5A, 32'hF0F0_F0F0, 32'h0000_0000, 4'd9,  32'd12345);
        send_add(32'h8000_0001, 32'h8000_0001, 32'hDEAD_BEEF, 4'd3,  32'h8000_0000);
    endtask

    task automatic test_lookup_directed();
        send_lookup(32'h0A02_0304);
        send_lookup(32'h0A01_0203);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0000_0000);
        // Hold off the next lookup until the table has answered everything.
        wait_for_answers();
        send_lookup(32'h5F5A_5F5A);
        send_lookup(32'h8123_4567);
        send_lookup(32'h0B00_0000);
        send_lookup(32'h7FFF_FFFE);
    endtask

    // Random traffic under each idling pattern, the table growing slowly.
    task automatic test_random_traffic();
        run_random_phase(360, 9,  3, 0,  0);
        run_random_phase(360, 11, 3, 85, 0);
        run_random_phase(360, 13, 3, 0,  85);
        run_random_phase(360, 15, 3, 8,  8);
    endtask

    // A default route catches every address; then the table fills up.
    task automatic test_default_route();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_add(32'h0000_0000, 32'h0000_0000, 32'hC0A8_00FE, 4'd2, 32'd10);
        while (route_cnt < MAX_ROUTES) add_random_route();
        send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
        send_lookup(32'h0B00_0000);
    endtask

    // Adds on a full table mixed with lookups that all hit.
    task automatic test_full_table();
        run_random_phase(190, MAX_ROUTES + 1, 30, 8, 8);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_req_type     = REQ_ADD;
        i_dest_addr    = '0;
        i_net_mask     = '0;
        i_gateway_addr = '0;
        i_iface_id     = '0;
        i_route_metric = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_add_extremes();
        test_lookup_directed();
        test_random_traffic();
        test_default_route();
        test_full_table();

        wait_for_answers();
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d answers: %0d adds, %0d full-table adds, %0d hits, %0d misses.",
                 n_added + n_full + n_hit + n_miss, n_added, n_full, n_hit, n_miss);
        $display("Table ended with %0d routes; %0d field mismatches.", route_cnt, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
